FILE: sv/assert_macros.svh
// assertion macros used by the port checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

FILE: sv/mlp_pkg.sv
// types, constants and arithmetic helpers for the perceptron forward pass
// no dependencies
package mlp_pkg;

    localparam int HIDDEN_COUNT = 8;

    localparam int AW        = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
    localparam int PROD_W    = 33;
    localparam int HSUM_W    = PROD_W + 1;
    localparam int ACC_W     = PROD_W + AW + 1;
    localparam int IDX_EXT_W = (($clog2(4 * HIDDEN_COUNT) > 5) ?
                                $clog2(4 * HIDDEN_COUNT) : 5) + 1;
    localparam int HSH_W     = HSUM_W - 12;
    localparam int OSH_W     = ACC_W - 16;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                operation;
        logic [4:0]         weight_index;
        logic signed [15:0] weight_value;
        logic signed [15:0] in_first;
        logic signed [15:0] in_second;
    } request_t;

    typedef struct packed
    {
        logic [15:0] out_first;
        logic [15:0] out_second;
    } result_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_LOAD,
        S_HMUL,
        S_HSUM,
        S_HSIG,
        S_OMUL,
        S_OACC,
        S_OSIG
    } state_t;

    typedef struct packed
    {
        logic          write_weight;
        logic          load_inputs;
        logic [AW-1:0] addr;
        logic          h_mul;
        logic          h_sum;
        logic          h_sig;
        logic          o_mul;
        logic          o_acc;
        logic          o_sig;
    } ctrl_t;

    function automatic logic [15:0] sigmoid(input logic signed [15:0] a);
        logic [16:0] m;
        logic [16:0] p;
        logic [16:0] r;
        m = a[15] ? (17'd0 - {a[15], a}) : {1'b0, a};
        priority if (m < 17'd4096)
            p = (m << 2) + 17'd32768;
        else if (m < 17'd9728)
            p = (m << 1) + 17'd40960;
        else if (m < 17'd20480)
            p = (m >> 1) + 17'd55296;
        else
            p = 17'd65536;
        r = a[15] ? (17'd65536 - p) : p;
        return r[16] ? 16'hFFFF : r[15:0];
    endfunction

    function automatic logic signed [15:0] sat_h(input logic signed [HSH_W-1:0] v);
        if ((&v[HSH_W-1:15]) || !(|v[HSH_W-1:15]))
            return v[15:0];
        return v[HSH_W-1] ? 16'sh8000 : 16'sh7FFF;
    endfunction

    function automatic logic signed [15:0] sat_o(input logic signed [OSH_W-1:0] v);
        if ((&v[OSH_W-1:15]) || !(|v[OSH_W-1:15]))
            return v[15:0];
        return v[OSH_W-1] ? 16'sh8000 : 16'sh7FFF;
    endfunction

endpackage

FILE: sv/mlp_two_in_two_out_forward.sv
// top level of the two-input, two-output perceptron forward pass
// depends on mlp_pkg, mlp_ctrl and mlp_datapath
//
//  channel   signals                  handshake
//  request   start, busy, request     taken when start and not busy
//  result    done, result             one-cycle strobe, no back-pressure
//
// a weight write completes in the cycle it is taken; busy stays low
// an evaluation holds busy through a load step, five sequencer steps per
// hidden node and a final output step, around two multipliers and one read
// port per weight bank; done pulses in the same cycle that busy drops
// reset clears the sequencer and the result register; weights are not cleared
module mlp_two_in_two_out_forward
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mlp_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output mlp_pkg::result_t  result
);

    mlp_pkg::ctrl_t ctrl;

    mlp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .busy      (busy),
        .done      (done),
        .ctrl      (ctrl)
    );

    mlp_datapath u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .request (request),
        .result  (result)
    );

endmodule

FILE: sv/mlp_datapath.sv
// weight banks, two shared multipliers, accumulators and sigmoid stages
// depends on mlp_pkg
module mlp_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  mlp_pkg::ctrl_t    ctrl,
    input  mlp_pkg::request_t request,
    output mlp_pkg::result_t  result
);

    logic signed [15:0] l1a_mem [mlp_pkg::HIDDEN_COUNT];
    logic signed [15:0] l1b_mem [mlp_pkg::HIDDEN_COUNT];
    logic signed [15:0] l2a_mem [mlp_pkg::HIDDEN_COUNT];
    logic signed [15:0] l2b_mem [mlp_pkg::HIDDEN_COUNT];

    logic signed [15:0] l1a_rd_reg, l1b_rd_reg, l2a_rd_reg, l2b_rd_reg;
    logic signed [15:0] x0_reg, x1_reg;
    logic signed [mlp_pkg::PROD_W-1:0] p0_reg, p0_next, p1_reg, p1_next;
    logic signed [mlp_pkg::HSUM_W-1:0] hsum_reg;
    logic        [15:0] hid_reg;
    logic signed [mlp_pkg::ACC_W-1:0] acc0_reg, acc1_reg;
    mlp_pkg::result_t result_reg;

    logic [mlp_pkg::IDX_EXT_W-1:0] idx_ext, off1, off2;
    logic [mlp_pkg::AW-1:0]        waddr1a, waddr1b, waddr2;
    logic we1a, we1b, we2a, we2b;

    logic signed [mlp_pkg::PROD_W-1:0] ma0, mb0, ma1, mb1;

    // write decode
    always_comb
    begin
        idx_ext = mlp_pkg::IDX_EXT_W'(request.weight_index);
        off1    = idx_ext - mlp_pkg::IDX_EXT_W'(mlp_pkg::HIDDEN_COUNT);
        off2    = idx_ext - mlp_pkg::IDX_EXT_W'(2 * mlp_pkg::HIDDEN_COUNT);
        waddr1a = idx_ext[mlp_pkg::AW-1:0];
        waddr1b = off1[mlp_pkg::AW-1:0];
        waddr2  = off2[mlp_pkg::AW:1];
        we1a = 1'b0;
        we1b = 1'b0;
        we2a = 1'b0;
        we2b = 1'b0;
        if (ctrl.write_weight)
        begin
            priority if (idx_ext < mlp_pkg::IDX_EXT_W'(mlp_pkg::HIDDEN_COUNT))
                we1a = 1'b1;
            else if (idx_ext < mlp_pkg::IDX_EXT_W'(2 * mlp_pkg::HIDDEN_COUNT))
                we1b = 1'b1;
            else if (idx_ext < mlp_pkg::IDX_EXT_W'(4 * mlp_pkg::HIDDEN_COUNT))
            begin
                we2a = !off2[0];
                we2b = off2[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we1a)
            l1a_mem[waddr1a] <= request.weight_value;
        if (we1b)
            l1b_mem[waddr1b] <= request.weight_value;
        if (we2a)
            l2a_mem[waddr2] <= request.weight_value;
        if (we2b)
            l2b_mem[waddr2] <= request.weight_value;
        l1a_rd_reg <= l1a_mem[ctrl.addr];
        l1b_rd_reg <= l1b_mem[ctrl.addr];
        l2a_rd_reg <= l2a_mem[ctrl.addr];
        l2b_rd_reg <= l2b_mem[ctrl.addr];
    end

    // operand selection for the two multipliers
    always_comb
    begin
        if (ctrl.o_mul)
        begin
            ma0 = mlp_pkg::PROD_W'(l2a_rd_reg);
            mb0 = mlp_pkg::PROD_W'({1'b0, hid_reg});
            ma1 = mlp_pkg::PROD_W'(l2b_rd_reg);
            mb1 = mlp_pkg::PROD_W'({1'b0, hid_reg});
        end
        else
        begin
            ma0 = mlp_pkg::PROD_W'(l1a_rd_reg);
            mb0 = mlp_pkg::PROD_W'(x0_reg);
            ma1 = mlp_pkg::PROD_W'(l1b_rd_reg);
            mb1 = mlp_pkg::PROD_W'(x1_reg);
        end
        p0_next = ma0 * mb0;
        p1_next = ma1 * mb1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_inputs)
        begin
            x0_reg <= request.in_first;
            x1_reg <= request.in_second;
        end
        if (ctrl.h_mul || ctrl.o_mul)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
        if (ctrl.h_sum)
            hsum_reg <= mlp_pkg::HSUM_W'(p0_reg) + mlp_pkg::HSUM_W'(p1_reg);
        if (ctrl.h_sig)
            hid_reg <= mlp_pkg::sigmoid(mlp_pkg::sat_h(
                $signed(hsum_reg[mlp_pkg::HSUM_W-1:12])));
        if (ctrl.load_inputs)
        begin
            acc0_reg <= '0;
            acc1_reg <= '0;
        end
        else if (ctrl.o_acc)
        begin
            acc0_reg <= acc0_reg + mlp_pkg::ACC_W'(p0_reg);
            acc1_reg <= acc1_reg + mlp_pkg::ACC_W'(p1_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_reg <= '0;
        else if (ctrl.o_sig)
        begin
            result_reg.out_first  <= mlp_pkg::sigmoid(mlp_pkg::sat_o(
                $signed(acc0_reg[mlp_pkg::ACC_W-1:16])));
            result_reg.out_second <= mlp_pkg::sigmoid(mlp_pkg::sat_o(
                $signed(acc1_reg[mlp_pkg::ACC_W-1:16])));
        end
    end

    assign result = result_reg;

endmodule

FILE: sv/mlp_ctrl.sv
// sequencer that walks the hidden nodes and drives the datapath commands
// depends on mlp_pkg
module mlp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  mlp_pkg::op_t   operation,
    output logic           busy,
    output logic           done,
    output mlp_pkg::ctrl_t ctrl
);

    mlp_pkg::state_t state_reg, state_next;
    logic [mlp_pkg::AW-1:0] cnt_reg, cnt_next;
    logic last_reg, last_next;
    logic done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlp_pkg::S_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        done_next  = 1'b0;
        ctrl       = '0;
        ctrl.addr  = cnt_reg;
        unique case (state_reg)
            mlp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (operation == mlp_pkg::OP_EVAL)
                    begin
                        ctrl.load_inputs = 1'b1;
                        last_next        = 1'b0;
                        state_next       = mlp_pkg::S_LOAD;
                    end
                    else
                        ctrl.write_weight = 1'b1;
                end
            end
            mlp_pkg::S_LOAD:
                state_next = mlp_pkg::S_HMUL;
            mlp_pkg::S_HMUL:
            begin
                ctrl.h_mul = 1'b1;
                state_next = mlp_pkg::S_HSUM;
            end
            mlp_pkg::S_HSUM:
            begin
                ctrl.h_sum = 1'b1;
                state_next = mlp_pkg::S_HSIG;
            end
            mlp_pkg::S_HSIG:
            begin
                ctrl.h_sig = 1'b1;
                state_next = mlp_pkg::S_OMUL;
            end
            mlp_pkg::S_OMUL:
            begin
                ctrl.o_mul = 1'b1;
                // advance early so the next read lands in time
                if (cnt_reg == mlp_pkg::AW'(mlp_pkg::HIDDEN_COUNT - 1))
                begin
                    cnt_next  = '0;
                    last_next = 1'b1;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
                state_next = mlp_pkg::S_OACC;
            end
            mlp_pkg::S_OACC:
            begin
                ctrl.o_acc = 1'b1;
                state_next = last_reg ? mlp_pkg::S_OSIG : mlp_pkg::S_HMUL;
            end
            mlp_pkg::S_OSIG:
            begin
                ctrl.o_sig = 1'b1;
                done_next  = 1'b1;
                state_next = mlp_pkg::S_IDLE;
            end
            default:
                state_next = mlp_pkg::S_IDLE;
        endcase
    end

    assign busy = (state_reg != mlp_pkg::S_IDLE);
    assign done = done_reg;

endmodule

FILE: sv/mlp_checker.sv
// port-level checks on the request and result transactions
// depends on mlp_pkg, assert_macros.svh and mlp_two_in_two_out_forward
`include "assert_macros.svh"

module mlp_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input mlp_pkg::request_t request,
    input logic              busy,
    input logic              done
);

    `ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "result while busy")
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "result strobe too long")
    `ASSERT_NEXT(a_write_free, clk, rst_n,
        start && !busy && (request.operation == mlp_pkg::OP_WRITE),
        !busy && !done, "write transaction blocked the port")
    `ASSERT_NEXT(a_eval_busy, clk, rst_n,
        start && !busy && (request.operation == mlp_pkg::OP_EVAL),
        busy && !done, "evaluate transaction not started")

endmodule

bind mlp_two_in_two_out_forward mlp_checker u_mlp_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done)
);
